// File: design/obas_pkg.sv
package obas_pkg;

   // Sizes of the item and register fields
   localparam int NUM_MOTORS_DEF = 8;
   localparam int TIME_W         = 32;
   localparam int CFG_W          = 16;
   localparam int MID_IN_W       = 3;
   localparam int CSR_IDX_W      = 2;
   localparam int PHASE_W        = 3;
   localparam int PEND_W         = 4;
   localparam int MASK_W         = 8;

   // Register reset values
   localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd100;
   localparam logic [CFG_W-1:0] BEEP_ON_RST    = 16'd100;
   localparam logic [CFG_W-1:0] BEEP_OFF_RST   = 16'd100;
   localparam logic [CFG_W-1:0] GROUP_WAIT_RST = 16'd2000;

   // Item command codes
   localparam logic CMD_TICK      = 1'b0;
   localparam logic CMD_HEARTBEAT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TIMEOUT    = 2'd0,
      REG_BEEP_ON    = 2'd1,
      REG_BEEP_OFF   = 2'd2,
      REG_GROUP_WAIT = 2'd3
   } reg_index_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE  = 3'd0,
      PH_BEEP  = 3'd1,
      PH_GAP   = 3'd2,
      PH_ROUND = 3'd3,
      PH_MOTOR = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HB,
      ST_SCAN,
      ST_SEQ,
      ST_REB,
      ST_REB_END,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_HB,
      OP_SCAN,
      OP_SEQ,
      OP_REB,
      OP_REB_END,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      logic idx_last;
      logic rebuild;
      logic out_free;
   } dp_status_type;

endpackage

// File: design/obas_ctrl.sv
module obas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_stall,
   input  obas_pkg::dp_status_type status,
   output obas_pkg::dp_op_type     op
);
   import obas_pkg::*;

   ctrl_state_type state_ff, state_in;

   // Hold the sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_HEARTBEAT) ? ST_HB : ST_SCAN;
            end
         end
         ST_HB:      state_in = ST_OUT;
         ST_SCAN: begin
            if (status.idx_last) begin
               state_in = ST_SEQ;
            end
         end
         ST_SEQ:     state_in = status.rebuild ? ST_REB : ST_OUT;
         ST_REB: begin
            if (status.idx_last) begin
               state_in = ST_REB_END;
            end
         end
         ST_REB_END: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      op        = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op = OP_CAPTURE;
            end
         end
         ST_HB:      op = OP_HB;
         ST_SCAN:    op = OP_SCAN;
         ST_SEQ:     op = OP_SEQ;
         ST_REB:     op = OP_REB;
         ST_REB_END: op = OP_REB_END;
         ST_OUT: begin
            if (status.out_free) begin
               op = OP_LOAD;
            end
         end
         default:    op = OP_NONE;
      endcase
   end

endmodule

// File: design/obas_dp.sv
module obas_dp #(
   parameter int NUM_MOTORS = obas_pkg::NUM_MOTORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  obas_pkg::dp_op_type             op,
   output obas_pkg::dp_status_type         status,
   input  logic                            csr_valid,
   input  logic [obas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [obas_pkg::CFG_W-1:0]      csr_wdata,
   input  logic [obas_pkg::MID_IN_W-1:0]   req_motor_id,
   input  logic [obas_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic                            rsp_beep_on,
   output logic [obas_pkg::PHASE_W-1:0]    rsp_alarm_phase,
   output logic [obas_pkg::MID_IN_W-1:0]   rsp_current_motor,
   output logic [obas_pkg::MASK_W-1:0]     rsp_offline_mask,
   output logic                            rsp_all_connected,
   output logic [obas_pkg::PEND_W-1:0]     rsp_pending_count
);
   import obas_pkg::*;

   localparam int MID_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int CNT_W = $clog2(NUM_MOTORS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_MOTORS);
   localparam logic [MID_W-1:0] IDX_LAST = MID_W'(NUM_MOTORS - 1);

   // Configuration registers
   logic [CFG_W-1:0] timeout_ff, beep_on_ff, beep_off_ff, group_wait_ff;

   // Captured item
   logic [MID_IN_W-1:0] id_ff, id_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // Motor and sequencer state
   logic [TIME_W-1:0]     last_ff [NUM_MOTORS];
   logic [TIME_W-1:0]     last_in [NUM_MOTORS];
   logic [NUM_MOTORS-1:0] off_ff, off_in, alarm_ff, alarm_in;
   logic [MID_W-1:0]      q_ff [NUM_MOTORS];
   logic [MID_W-1:0]      q_in [NUM_MOTORS];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   phase_type             phase_ff, phase_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [MID_W-1:0]      beep_ff, beep_in;
   logic [CNT_W-1:0]      done_ff, done_in;
   logic                  conn_ff, conn_in;
   logic [MID_W-1:0]      idx_ff, idx_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                buzz_ff;
   logic [PHASE_W-1:0]  phase_out_ff;
   logic [MID_IN_W-1:0] cur_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic                conn_out_ff;
   logic [PEND_W-1:0]   pend_ff;
   logic [MASK_W-1:0]   mask_now;

   // Shared helpers
   logic [MID_W-1:0]  id_m, rm_m;
   logic              hb_ok;
   logic [TIME_W-1:0] elapsed;
   logic              scan_late;
   logic              wait_on, wait_off, wait_group;
   logic [CNT_W-1:0]  done_inc;
   logic [MID_W-1:0]  q_rm [NUM_MOTORS];
   logic [CNT_W-1:0]  cnt_rm;
   logic              rm_found;
   logic [MID_W-1:0]  q_add [NUM_MOTORS];
   logic [CNT_W-1:0]  cnt_add;
   logic              add_en, add_dup;
   logic [MID_W-1:0]  q_pop [NUM_MOTORS];

   assign id_m       = MID_W'(id_ff);
   assign hb_ok      = ({1'b0, id_ff} < (MID_IN_W+1)'(NUM_MOTORS)) ||
                       (NUM_MOTORS > (1 << MID_IN_W));
   assign elapsed    = now_ff - start_ff;
   assign scan_late  = (now_ff - last_ff[idx_ff]) > {{(TIME_W-CFG_W){1'b0}}, timeout_ff};
   assign wait_on    = elapsed >= {{(TIME_W-CFG_W){1'b0}}, beep_on_ff};
   assign wait_off   = elapsed >= {{(TIME_W-CFG_W){1'b0}}, beep_off_ff};
   assign wait_group = elapsed >= {{(TIME_W-CFG_W){1'b0}}, group_wait_ff};
   assign done_inc   = done_ff + CNT_W'(1);
   assign rm_m       = (op == OP_HB) ? id_m : beep_ff;

   // Remove one motor from the queue: shift down every entry past its slot
   always_comb begin
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         if ((CNT_W'(k) < cnt_ff) && (q_ff[k] == rm_m)) begin
            hit = 1'b1;
         end
         if (hit && (k < NUM_MOTORS - 1)) begin
            q_rm[k] = q_ff[(k + 1) % NUM_MOTORS];
         end else begin
            q_rm[k] = q_ff[k];
         end
      end
      rm_found = hit;
      cnt_rm   = cnt_ff - CNT_W'(hit);
   end

   // Append the scanned motor unless it is already queued or the queue is full
   always_comb begin
      add_en  = (op == OP_SCAN) ? (scan_late && !off_ff[idx_ff])
                                : (off_ff[idx_ff] && alarm_ff[idx_ff]);
      add_dup = 1'b0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         if ((CNT_W'(k) < cnt_ff) && (q_ff[k] == idx_ff)) begin
            add_dup = 1'b1;
         end
      end
      for (int k = 0; k < NUM_MOTORS; k++) begin
         q_add[k] = (!add_dup && (cnt_ff < CNT_FULL) && (CNT_W'(k) == cnt_ff))
                    ? idx_ff : q_ff[k];
      end
      cnt_add = cnt_ff + CNT_W'(!add_dup && (cnt_ff < CNT_FULL));
   end

   // Drop the head entry
   always_comb begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
         q_pop[k] = (k < NUM_MOTORS - 1) ? q_ff[(k + 1) % NUM_MOTORS] : q_ff[k];
      end
   end

   // Offline bits as seen on the result
   always_comb begin
      mask_now = '0;
      for (int k = 0; k < NUM_MOTORS && k < MASK_W; k++) begin
         mask_now[k] = off_ff[k];
      end
   end

   // Next state of the motor table, queue and sequencer
   always_comb begin
      id_in        = id_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      off_in       = off_ff;
      alarm_in     = alarm_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      start_in     = start_ff;
      beep_in      = beep_ff;
      done_in      = done_ff;
      conn_in      = conn_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (op)
         OP_CAPTURE: begin
            id_in  = req_motor_id;
            now_in = req_now_ms;
            idx_in = '0;
         end
         OP_HB: begin
            if (hb_ok) begin
               for (int k = 0; k < NUM_MOTORS; k++) begin
                  if (MID_W'(k) == id_m) begin
                     last_in[k] = now_ff;
                  end
               end
               off_in[id_m] = 1'b0;
               if (alarm_ff[id_m]) begin
                  alarm_in[id_m] = 1'b0;
                  q_in           = q_rm;
                  cnt_in         = cnt_rm;
                  if (beep_ff == id_m) begin
                     phase_in = PH_IDLE;
                     beep_in  = '0;
                     done_in  = '0;
                  end
               end
            end
         end
         OP_SCAN: begin
            if (add_en) begin
               off_in[idx_ff]   = 1'b1;
               alarm_in[idx_ff] = 1'b1;
               q_in             = q_add;
               cnt_in           = cnt_add;
            end
            idx_in = idx_ff + MID_W'(1);
         end
         OP_SEQ: begin
            conn_in = ~|off_ff;
            case (phase_ff)
               PH_IDLE: begin
                  if (cnt_ff != '0) begin
                     beep_in  = q_ff[0];
                     q_in     = q_pop;
                     cnt_in   = cnt_ff - CNT_W'(1);
                     done_in  = '0;
                     phase_in = PH_BEEP;
                     start_in = now_ff;
                  end
               end
               PH_BEEP: begin
                  if (wait_on) begin
                     phase_in = PH_GAP;
                     start_in = now_ff;
                  end
               end
               PH_GAP: begin
                  if (wait_off) begin
                     done_in  = done_inc;
                     start_in = now_ff;
                     if (done_inc > CNT_W'(beep_ff)) begin
                        phase_in = (cnt_ff != '0) ? PH_MOTOR : PH_ROUND;
                     end else begin
                        phase_in = PH_BEEP;
                     end
                  end
               end
               PH_ROUND: begin
                  if (wait_group) begin
                     if (off_ff[beep_ff]) begin
                        // empty the queue, then rebuild it in the rebuild scan
                        cnt_in = '0;
                        idx_in = '0;
                     end else begin
                        q_in              = q_rm;
                        cnt_in            = cnt_rm;
                        alarm_in[beep_ff] = 1'b0;
                        if (cnt_rm != '0) begin
                           phase_in = PH_MOTOR;
                           start_in = now_ff;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end
                  end
               end
               PH_MOTOR: begin
                  if (wait_group) begin
                     if (cnt_ff != '0) begin
                        beep_in  = q_ff[0];
                        q_in     = q_pop;
                        cnt_in   = cnt_ff - CNT_W'(1);
                        done_in  = '0;
                        phase_in = PH_BEEP;
                        start_in = now_ff;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         OP_REB: begin
            if (add_en) begin
               q_in   = q_add;
               cnt_in = cnt_add;
            end
            idx_in = idx_ff + MID_W'(1);
         end
         OP_REB_END: begin
            if (cnt_ff != '0) begin
               beep_in  = q_ff[0];
               q_in     = q_pop;
               cnt_in   = cnt_ff - CNT_W'(1);
               done_in  = '0;
               phase_in = PH_BEEP;
               start_in = now_ff;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         OP_LOAD: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RST;
         beep_on_ff    <= BEEP_ON_RST;
         beep_off_ff   <= BEEP_OFF_RST;
         group_wait_ff <= GROUP_WAIT_RST;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_TIMEOUT:    timeout_ff    <= csr_wdata;
            REG_BEEP_ON:    beep_on_ff    <= csr_wdata;
            REG_BEEP_OFF:   beep_off_ff   <= csr_wdata;
            REG_GROUP_WAIT: group_wait_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_MOTORS; k++) begin
            last_ff[k] <= '0;
         end
         off_ff       <= '0;
         alarm_ff     <= '0;
         cnt_ff       <= '0;
         phase_ff     <= PH_IDLE;
         start_ff     <= '0;
         beep_ff      <= '0;
         done_ff      <= '0;
         conn_ff      <= 1'b1;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         off_ff       <= off_in;
         alarm_ff     <= alarm_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         beep_ff      <= beep_in;
         done_ff      <= done_in;
         conn_ff      <= conn_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and queue payload
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      now_ff <= now_in;
      q_ff   <= q_in;
      if (op == OP_LOAD) begin
         buzz_ff      <= (phase_ff == PH_BEEP);
         phase_out_ff <= phase_ff;
         cur_ff       <= MID_IN_W'(beep_ff);
         mask_ff      <= mask_now;
         conn_out_ff  <= conn_ff;
         pend_ff      <= PEND_W'(cnt_ff);
      end
   end

   // Status to the controller
   assign status.idx_last = (idx_ff == IDX_LAST);
   assign status.rebuild  = (phase_ff == PH_ROUND) && wait_group && off_ff[beep_ff];
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_beep_on       = buzz_ff;
   assign rsp_alarm_phase   = phase_out_ff;
   assign rsp_current_motor = cur_ff;
   assign rsp_offline_mask  = mask_ff;
   assign rsp_all_connected = conn_out_ff;
   assign rsp_pending_count = pend_ff;

endmodule

// File: design/offline_beep_alarm_sequencer.sv
// Offline beep alarm sequencer: watches motor heartbeats and beeps out offline motors.
//
// Channels: req_* carries one beat per tick (req_cmd 0) or heartbeat (req_cmd 1)
// with a millisecond time stamp; rsp_* returns one beat per request with the
// buzzer, alarm phase, beeped motor, offline mask, connection flag and queue
// depth as they stand after that request. csr_* writes the four timing
// registers; csr_ready is always high, writes belong to idle periods.
// Timing: a heartbeat passes through the capture, heartbeat and output states;
// a tick passes through capture, a scan of each motor in turn, the sequencer
// step and output, plus a rebuild scan of each motor when a round ends and the
// queue is rebuilt. The per-motor scans share one compare unit.
// One request is worked on at a time; the next is taken once the result of
// the previous one sits in the output register.
// Reset (synchronous) clears all time stamps, flags, the queue and the
// sequencer and loads the register defaults. When rsp_stall is high the result
// beat holds and the block takes at most one more request, whose result waits
// until the held beat is taken.
module offline_beep_alarm_sequencer #(
   parameter int NUM_MOTORS = obas_pkg::NUM_MOTORS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [obas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [obas_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [obas_pkg::MID_IN_W-1:0]  req_motor_id,
   input  logic [obas_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_beep_on,
   output logic [obas_pkg::PHASE_W-1:0]   rsp_alarm_phase,
   output logic [obas_pkg::MID_IN_W-1:0]  rsp_current_motor,
   output logic [obas_pkg::MASK_W-1:0]    rsp_offline_mask,
   output logic                           rsp_all_connected,
   output logic [obas_pkg::PEND_W-1:0]    rsp_pending_count
);
   import obas_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   // Registers are always writable
   assign csr_ready = 1'b1;

   obas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   obas_dp #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_motor_id      (req_motor_id),
      .req_now_ms        (req_now_ms),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_beep_on       (rsp_beep_on),
      .rsp_alarm_phase   (rsp_alarm_phase),
      .rsp_current_motor (rsp_current_motor),
      .rsp_offline_mask  (rsp_offline_mask),
      .rsp_all_connected (rsp_all_connected),
      .rsp_pending_count (rsp_pending_count)
   );

endmodule

// File: design/obas_check.sv
module obas_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_beep_on,
   input logic [obas_pkg::PHASE_W-1:0]   rsp_alarm_phase,
   input logic [obas_pkg::PEND_W-1:0]    rsp_pending_count
);
   import obas_pkg::*;

   // Buzzer sounds exactly in the beep phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_beep_on == (rsp_alarm_phase == PH_BEEP)))
      else $error("buzzer disagrees with alarm phase");

   // Phase code stays within the five phases
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm_phase <= PH_MOTOR))
      else $error("alarm phase out of range");

   // Queue never holds more than eight motors
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pending_count <= PEND_W'(8)))
      else $error("pending count too large");

   // A stalled result beat stays
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_alarm_phase)))
      else $error("stalled result dropped");

endmodule

bind offline_beep_alarm_sequencer obas_check u_obas_check (.*);
